/* hdl/range_table_code_mapper_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the range table code mapper
// Both macros use the clk and rst_n of the module that includes them.
// ---------------------------------------------------------------------------
`ifndef RANGE_TABLE_CODE_MAPPER_TOP_ASSERT_SVH
`define RANGE_TABLE_CODE_MAPPER_TOP_ASSERT_SVH

// same-cycle implication
`define RTCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTCM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rtcm_pkg.sv */
// ---------------------------------------------------------------------------
// rtcm_pkg
// Shared sizes, codes and table word types of the range table code mapper.
// ---------------------------------------------------------------------------
package rtcm_pkg;

    // table sizes
    localparam int RANGE_ENTRIES   = 256;
    localparam int EXTRA_ENTRIES   = 64;
    localparam int EXTRA_MAX_BYTES = 8;

    localparam int RANGE_MAX_BYTES = 4;
    localparam logic [7:0] BYTE_MASK = 8'hff;

    // address widths and count widths (count can hold the depth itself)
    localparam int RANGE_AW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int RANGE_CW = $clog2(RANGE_ENTRIES + 1);
    localparam int EXTRA_AW = (EXTRA_ENTRIES > 1) ? $clog2(EXTRA_ENTRIES) : 1;
    localparam int EXTRA_CW = $clog2(EXTRA_ENTRIES + 1);
    localparam int EXTRA_BW = EXTRA_MAX_BYTES * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COUNT = 1'd1;

    // request types
    localparam logic [1:0] REQ_RANGE_WR = 2'd0;
    localparam logic [1:0] REQ_EXTRA_WR = 2'd1;
    localparam logic [1:0] REQ_MAP      = 2'd2;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] last;
        logic [31:0] code;
        logic [2:0]  len;
    } range_word_t;

    typedef struct packed {
        logic [31:0]         key;
        logic [EXTRA_BW-1:0] bytes;
        logic [3:0]          len;
    } extra_word_t;

    localparam int RANGE_WORD_W = $bits(range_word_t);
    localparam int EXTRA_WORD_W = $bits(extra_word_t);

    // controller to table memory
    typedef struct packed {
        logic                we;
        logic [RANGE_AW-1:0] waddr;
        range_word_t         wdata;
        logic                re;
        logic [RANGE_AW-1:0] raddr;
    } range_port_t;

    typedef struct packed {
        logic                we;
        logic [EXTRA_AW-1:0] waddr;
        extra_word_t         wdata;
        logic                re;
        logic [EXTRA_AW-1:0] raddr;
    } extra_port_t;

endpackage

/* hdl/rtcm_ifs.sv */
// ---------------------------------------------------------------------------
// rtcm_req_if / rtcm_rsp_if
// Valid/ready channels for requests and results of the code mapper.
// ---------------------------------------------------------------------------
interface rtcm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [31:0] code_point;
    logic [31:0] range_last;
    logic [31:0] base_code;
    logic [3:0]  code_len;
    logic [63:0] extra_bytes;
    logic [7:0]  buf_size;

    modport source (
        output valid, req_type, entry_index, code_point, range_last,
               base_code, code_len, extra_bytes, buf_size,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, code_point, range_last,
               base_code, code_len, extra_bytes, buf_size,
        output ready
    );
endinterface

interface rtcm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  out_len;
    logic [63:0] out_bytes;

    modport source (
        output valid, status, out_len, out_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, out_len, out_bytes,
        output ready
    );
endinterface

/* hdl/rtcm_ram.sv */
// ---------------------------------------------------------------------------
// rtcm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rtcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/rtcm_ctrl.sv */
// ---------------------------------------------------------------------------
// rtcm_ctrl
// Request sequencer: table loads, binary search of the range table,
// ordered scan of the extra table, result register.
// ---------------------------------------------------------------------------
`include "range_table_code_mapper_top_assert.svh"

module rtcm_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    rtcm_req_if.sink                            req,
    rtcm_rsp_if.source                          rsp,
    output rtcm_pkg::range_port_t               range_port,
    input  rtcm_pkg::range_word_t               range_rdata,
    output rtcm_pkg::extra_port_t               extra_port,
    input  rtcm_pkg::extra_word_t               extra_rdata
);

    localparam int RAW = rtcm_pkg::RANGE_AW;
    localparam int RCW = rtcm_pkg::RANGE_CW;
    localparam int EAW = rtcm_pkg::EXTRA_AW;
    localparam int ECW = rtcm_pkg::EXTRA_CW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_R0     = 4'd1;
    localparam logic [3:0] S_SISSUE = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_RES    = 4'd4;
    localparam logic [3:0] S_CODE   = 4'd5;
    localparam logic [3:0] S_XSCAN  = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    // range code to big-endian bytes, byte 0 in the low bits
    function automatic logic [63:0] code_bytes(input logic [31:0] code,
                                               input logic [2:0] n);
        logic [5:0]  amt;
        logic [31:0] aligned;
        logic [63:0] res;
        amt     = {3'(3'd4 - n), 3'b000};
        aligned = code << amt;
        res     = '0;
        for (int i = 0; i < rtcm_pkg::RANGE_MAX_BYTES; i++)
        begin
            if (3'(i) < n)
            begin
                res[8*i +: 8] = aligned[31-8*i -: 8] & rtcm_pkg::BYTE_MASK;
            end
        end
        return res;
    endfunction

    // extra entry bytes below the length, rest cleared
    function automatic logic [63:0] keep_bytes(input logic [rtcm_pkg::EXTRA_BW-1:0] v,
                                               input logic [3:0] n);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < rtcm_pkg::EXTRA_MAX_BYTES; i++)
        begin
            if (4'(i) < n)
            begin
                res[8*i +: 8] = v[8*i +: 8];
            end
        end
        return res;
    endfunction

    logic [3:0]              state_reg, state_next;
    logic [8:0]              range_count_reg;
    logic [6:0]              extra_count_reg;
    logic [31:0]             point_reg, point_next;
    logic [7:0]              room_reg, room_next;
    logic [RCW-1:0]          a_reg, a_next;
    logic [RCW-1:0]          b_reg, b_next;
    logic [RAW-1:0]          m_reg, m_next;
    rtcm_pkg::range_word_t   hit_reg, hit_next;
    logic [31:0]             off_reg, off_next;
    logic [ECW-1:0]          x_idx_reg, x_idx_next;
    logic                    pend_reg, pend_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic [3:0]              res_len_reg, res_len_next;
    logic [63:0]             res_bytes_reg, res_bytes_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg;
    logic [3:0]              out_len_reg;
    logic [63:0]             out_bytes_reg;

    logic [RCW-1:0]          nr;
    logic [ECW-1:0]          ne;
    logic                    req_xfer;
    logic                    out_load;
    logic                    x_issue;
    logic [RCW:0]            ab_sum;
    logic [RCW-1:0]          a_new, b_new;
    logic [31:0]             code_sum;

    // entries in use, clipped to the table depth
    assign nr = (32'(range_count_reg) > rtcm_pkg::RANGE_ENTRIES)
                ? RCW'(rtcm_pkg::RANGE_ENTRIES) : RCW'(range_count_reg);
    assign ne = (32'(extra_count_reg) > rtcm_pkg::EXTRA_ENTRIES)
                ? ECW'(rtcm_pkg::EXTRA_ENTRIES) : ECW'(extra_count_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    assign ab_sum   = {1'b0, a_reg} + {1'b0, b_reg};
    assign x_issue  = (x_idx_reg < ne);
    assign code_sum = hit_reg.code + off_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        point_next      = point_reg;
        room_next       = room_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        m_next          = m_reg;
        hit_next        = hit_reg;
        off_next        = off_reg;
        x_idx_next      = x_idx_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_len_next    = res_len_reg;
        res_bytes_next  = res_bytes_reg;
        a_new           = a_reg;
        b_new           = b_reg;

        range_port             = '0;
        range_port.waddr       = RAW'(req.entry_index);
        range_port.wdata.start = req.code_point;
        range_port.wdata.last  = req.range_last;
        range_port.wdata.code  = req.base_code;
        range_port.wdata.len   = (req.code_len > 4'(rtcm_pkg::RANGE_MAX_BYTES))
                                 ? 3'(rtcm_pkg::RANGE_MAX_BYTES) : req.code_len[2:0];

        extra_port             = '0;
        extra_port.waddr       = EAW'(req.entry_index);
        extra_port.wdata.key   = req.code_point;
        extra_port.wdata.bytes = req.extra_bytes[rtcm_pkg::EXTRA_BW-1:0];
        extra_port.wdata.len   = (req.code_len > 4'(rtcm_pkg::EXTRA_MAX_BYTES))
                                 ? 4'(rtcm_pkg::EXTRA_MAX_BYTES) : req.code_len;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    point_next      = req.code_point;
                    room_next       = req.buf_size;
                    res_status_next = rtcm_pkg::ST_OK;
                    res_len_next    = '0;
                    res_bytes_next  = '0;
                    x_idx_next      = '0;
                    pend_next       = 1'b0;
                    state_next      = S_FINISH;
                    case (req.req_type)
                        rtcm_pkg::REQ_RANGE_WR:
                        begin
                            range_port.we = (32'(req.entry_index) < rtcm_pkg::RANGE_ENTRIES);
                        end
                        rtcm_pkg::REQ_EXTRA_WR:
                        begin
                            extra_port.we = (32'(req.entry_index) < rtcm_pkg::EXTRA_ENTRIES);
                        end
                        rtcm_pkg::REQ_MAP:
                        begin
                            if (nr != '0)
                            begin
                                range_port.re    = 1'b1;
                                range_port.raddr = '0;
                                state_next       = S_R0;
                            end
                            else
                            begin
                                state_next = S_XSCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // first entry: point below it goes straight to the extra table
            S_R0:
            begin
                if (point_reg < range_rdata.start)
                begin
                    state_next = S_XSCAN;
                end
                else
                begin
                    hit_next   = range_rdata;
                    a_next     = '0;
                    b_next     = nr;
                    state_next = (nr > RCW'(1)) ? S_SISSUE : S_RES;
                end
            end

            // read the midpoint
            S_SISSUE:
            begin
                m_next           = RAW'(ab_sum >> 1);
                range_port.re    = 1'b1;
                range_port.raddr = RAW'(ab_sum >> 1);
                state_next       = S_SCMP;
            end

            // narrow the interval
            S_SCMP:
            begin
                if (point_reg >= range_rdata.start)
                begin
                    a_new    = RCW'(m_reg);
                    hit_next = range_rdata;
                end
                else
                begin
                    b_new = RCW'(m_reg);
                end
                a_next     = a_new;
                b_next     = b_new;
                state_next = ((b_new - a_new) > RCW'(1)) ? S_SISSUE : S_RES;
            end

            // last entry at or below the point: check its end and length
            S_RES:
            begin
                if (point_reg <= hit_reg.last)
                begin
                    if ({5'b0, hit_reg.len} > room_reg)
                    begin
                        res_status_next = rtcm_pkg::ST_TOO_LONG;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        off_next   = point_reg - hit_reg.start;
                        state_next = S_CODE;
                    end
                end
                else
                begin
                    state_next = S_XSCAN;
                end
            end

            S_CODE:
            begin
                res_status_next = rtcm_pkg::ST_OK;
                res_len_next    = {1'b0, hit_reg.len};
                res_bytes_next  = code_bytes(code_sum, hit_reg.len);
                state_next      = S_FINISH;
            end

            // ordered scan, one read issued and one entry compared per cycle
            S_XSCAN:
            begin
                if (x_issue)
                begin
                    extra_port.re    = 1'b1;
                    extra_port.raddr = x_idx_reg[EAW-1:0];
                    x_idx_next       = x_idx_reg + ECW'(1);
                end
                pend_next = x_issue;
                if (pend_reg && (extra_rdata.key == point_reg))
                begin
                    if (8'(extra_rdata.len) > room_reg)
                    begin
                        res_status_next = rtcm_pkg::ST_TOO_LONG;
                    end
                    else
                    begin
                        res_status_next = rtcm_pkg::ST_OK;
                        res_len_next    = extra_rdata.len;
                        res_bytes_next  = keep_bytes(extra_rdata.bytes, extra_rdata.len);
                    end
                    state_next = S_FINISH;
                end
                else if (!x_issue)
                begin
                    res_status_next = rtcm_pkg::ST_NO_MATCH;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: held until the sink takes the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            range_count_reg <= '0;
            extra_count_reg <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rtcm_pkg::CFG_RANGE_COUNT: range_count_reg <= cfg_data;
                    rtcm_pkg::CFG_EXTRA_COUNT: extra_count_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        point_reg      <= point_next;
        room_reg       <= room_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        m_reg          <= m_next;
        hit_reg        <= hit_next;
        off_reg        <= off_next;
        x_idx_reg      <= x_idx_next;
        res_status_reg <= res_status_next;
        res_len_reg    <= res_len_next;
        res_bytes_reg  <= res_bytes_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_len_reg    <= res_len_reg;
            out_bytes_reg  <= res_bytes_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_len   = out_len_reg;
    assign rsp.out_bytes = out_bytes_reg;

    // checks
    `RTCM_ASSERT_NXT(a_busy_after_xfer, req_xfer, state_reg != S_IDLE,
        "request transfer did not start work")
    `RTCM_ASSERT_NOW(a_mid_inside, state_reg == S_SCMP,
        (a_reg < RCW'(m_reg)) && (RCW'(m_reg) < b_reg) && (b_reg <= nr),
        "binary search midpoint outside its interval")
    `RTCM_ASSERT_NOW(a_scan_pending, (state_reg == S_XSCAN) && pend_reg,
        $past(extra_port.re), "extra compare without a read issued")
    `RTCM_ASSERT_NXT(a_result_loaded, out_load, out_valid_reg,
        "finished result not presented")

endmodule

/* hdl/range_table_code_mapper_top.sv */
// Loads and ignored requests pass from the transfer to S_FINISH and then to the
// output register once that is free. Map: a binary search of the range table, each
// step reading the midpoint (S_SISSUE) and comparing it (S_SCMP); on a range miss,
// a scan of the extra table, one memory read a cycle. One request is in work at a
// time. Reset clears the two count registers and the handshake state; table memories
// are not cleared and hold undefined entries until written.
// ---------------------------------------------------------------------------
// range_table_code_mapper_top
// Code point to byte sequence mapper over a sorted range table and an
// extra single-point table, both held in synchronous RAM.
// ---------------------------------------------------------------------------
module range_table_code_mapper_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rtcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtcm_pkg::CFG_DATA_W-1:0] cfg_data,
    rtcm_req_if.sink                        req,
    rtcm_rsp_if.source                      rsp
);

    rtcm_pkg::range_port_t range_port;
    rtcm_pkg::extra_port_t extra_port;
    logic [rtcm_pkg::RANGE_WORD_W-1:0] range_rvec;
    logic [rtcm_pkg::EXTRA_WORD_W-1:0] extra_rvec;
    rtcm_pkg::range_word_t range_rdata;
    rtcm_pkg::extra_word_t extra_rdata;

    assign range_rdata = rtcm_pkg::range_word_t'(range_rvec);
    assign extra_rdata = rtcm_pkg::extra_word_t'(extra_rvec);

    // sequencer
    rtcm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .rsp         (rsp),
        .range_port  (range_port),
        .range_rdata (range_rdata),
        .extra_port  (extra_port),
        .extra_rdata (extra_rdata)
    );

    // range table: start, last, base code, length
    rtcm_ram #(
        .WIDTH (rtcm_pkg::RANGE_WORD_W),
        .DEPTH (rtcm_pkg::RANGE_ENTRIES),
        .AW    (rtcm_pkg::RANGE_AW)
    ) u_range_ram (
        .clk   (clk),
        .we    (range_port.we),
        .waddr (range_port.waddr),
        .wdata (range_port.wdata),
        .re    (range_port.re),
        .raddr (range_port.raddr),
        .rdata (range_rvec)
    );

    // extra table: key, bytes, length
    rtcm_ram #(
        .WIDTH (rtcm_pkg::EXTRA_WORD_W),
        .DEPTH (rtcm_pkg::EXTRA_ENTRIES),
        .AW    (rtcm_pkg::EXTRA_AW)
    ) u_extra_ram (
        .clk   (clk),
        .we    (extra_port.we),
        .waddr (extra_port.waddr),
        .wdata (extra_port.wdata),
        .re    (extra_port.re),
        .raddr (extra_port.raddr),
        .rdata (extra_rvec)
    );

endmodule
